// File: design/gmc_pkg.sv
package gmc_pkg;

  // Command codes of the input word.
  localparam logic [1:0] CMD_G0 = 2'd0;
  localparam logic [1:0] CMD_G1 = 2'd1;

  // Move classes of the result word.
  localparam logic [2:0] CLS_NONE    = 3'd0;
  localparam logic [2:0] CLS_EXTRUDE = 3'd1;
  localparam logic [2:0] CLS_TRAVEL  = 3'd2;
  localparam logic [2:0] CLS_PRIME   = 3'd3;
  localparam logic [2:0] CLS_SUCK    = 3'd4;

  // Feed rate width is fixed.
  localparam int unsigned FEED_BITS = 32;

  // Back end sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQR  = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } back_state_e;

endpackage

// File: design/gcode_move_classifier_core.sv
// G-code move classifier.
// Input channel: one pre-parsed G0/G1 move per word (in_valid_i, in_stall_o).
// Absent axes and feed keep the last resolved value; other codes return an
// all-zero word with class none and leave the position untouched.
// Output channel: one result word per input word (out_valid_o, out_stall_i),
// carrying the resolved values, floor XYZ length, E delta, Q-format flow and
// move class.
// The front end resolves a move in the accept cycle and writes it into a
// two-word queue; it stalls only when that queue is full.
// The back end takes one word at a time: shift-add squaring of the three
// axes, COORD_BITS+1 square-root steps and COORD_BITS+FLOW_FRAC_BITS
// divide steps, then the result; an accepted word is registered in the
// queue before the back end can pop it.
// An ignored code skips the arithmetic and goes from the pop straight to
// the result.
// The result stays on the output while the receiver stalls; the queue keeps
// accepting until it is full.
// Reset clears the held position and feed to zero and empties the queue.
module gcode_move_classifier_core #(
  parameter int unsigned COORD_BITS     = 32,
  parameter int unsigned FLOW_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            cmd_i,
  input  logic [COORD_BITS-1:0] x_value_i,
  input  logic [COORD_BITS-1:0] y_value_i,
  input  logic [COORD_BITS-1:0] z_value_i,
  input  logic [COORD_BITS-1:0] e_value_i,
  input  logic [31:0]           feed_value_i,
  input  logic                  has_x_i,
  input  logic                  has_y_i,
  input  logic                  has_z_i,
  input  logic                  has_e_i,
  input  logic                  has_feed_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            move_class_o,
  output logic [COORD_BITS-1:0] out_x_o,
  output logic [COORD_BITS-1:0] out_y_o,
  output logic [COORD_BITS-1:0] out_z_o,
  output logic [COORD_BITS-1:0] out_e_o,
  output logic [31:0]           out_feed_o,
  output logic [COORD_BITS:0]   move_length_o,
  output logic [COORD_BITS:0]   extrude_delta_o,
  output logic [31:0]           flow_ratio_o
);

  localparam int unsigned EW = 8 * COORD_BITS + gmc_pkg::FEED_BITS + 2;

  logic          push, full, pop, q_valid;
  logic [EW-1:0] push_data, pop_data;

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  gmc_front #(.W(COORD_BITS), .EW(EW)) u_front (
    .clk_i, .rst_ni, .push_i(push), .cmd_i, .x_value_i, .y_value_i, .z_value_i,
    .e_value_i, .feed_value_i, .has_x_i, .has_y_i, .has_z_i, .has_e_i,
    .has_feed_i, .entry_o(push_data)
  );

  gmc_queue #(.EW(EW)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .pop_data_o(pop_data)
  );

  gmc_back #(.W(COORD_BITS), .F(FLOW_FRAC_BITS), .EW(EW)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .entry_i(pop_data), .pop_o(pop),
    .out_valid_o, .out_stall_i, .move_class_o, .out_x_o, .out_y_o, .out_z_o,
    .out_e_o, .out_feed_o, .move_length_o, .extrude_delta_o, .flow_ratio_o
  );

`ifndef NO_ASSERTIONS
  // A moving class needs a nonzero length.
  a_len_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (move_class_o == gmc_pkg::CLS_EXTRUDE ||
                    move_class_o == gmc_pkg::CLS_TRAVEL) |-> move_length_o != '0)
    else $error("moving class with zero length");

  // Flow is zero whenever the length is zero.
  a_flow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && move_length_o == '0 |-> flow_ratio_o == '0)
    else $error("flow nonzero for zero length");

  // Class none only for an all-zero word.
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && move_class_o == gmc_pkg::CLS_NONE |->
      move_length_o == '0 && extrude_delta_o == '0 && out_feed_o == '0)
    else $error("class none with nonzero fields");
`endif

endmodule

// File: design/gmc_front.sv
module gmc_front #(
  parameter int unsigned W  = 32,
  parameter int unsigned EW = 8 * W + 34
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [1:0]          cmd_i,
  input  logic [W-1:0]        x_value_i,
  input  logic [W-1:0]        y_value_i,
  input  logic [W-1:0]        z_value_i,
  input  logic [W-1:0]        e_value_i,
  input  logic [31:0]         feed_value_i,
  input  logic                has_x_i,
  input  logic                has_y_i,
  input  logic                has_z_i,
  input  logic                has_e_i,
  input  logic                has_feed_i,
  output logic [EW-1:0]       entry_o
);

  logic [W-1:0] last_x_q, last_y_q, last_z_q, last_e_q;
  logic [31:0]  last_f_q;
  logic [W-1:0] nx, ny, nz, ne;
  logic [31:0]  nf;
  logic [W:0]   dx, dy, dz, de;
  logic [W-1:0] ax, ay, az;
  logic         ign;

  // Resolve absent words from the held position.
  assign ign = (cmd_i != gmc_pkg::CMD_G0) && (cmd_i != gmc_pkg::CMD_G1);
  assign nx  = has_x_i ? x_value_i : last_x_q;
  assign ny  = has_y_i ? y_value_i : last_y_q;
  assign nz  = has_z_i ? z_value_i : last_z_q;
  assign ne  = has_e_i ? e_value_i : last_e_q;
  assign nf  = has_feed_i ? feed_value_i : last_f_q;

  // Signed deltas and their magnitudes.
  assign dx = {nx[W-1], nx} - {last_x_q[W-1], last_x_q};
  assign dy = {ny[W-1], ny} - {last_y_q[W-1], last_y_q};
  assign dz = {nz[W-1], nz} - {last_z_q[W-1], last_z_q};
  assign de = {ne[W-1], ne} - {last_e_q[W-1], last_e_q};
  assign ax = dx[W] ? W'(-dx) : dx[W-1:0];
  assign ay = dy[W] ? W'(-dy) : dy[W-1:0];
  assign az = dz[W] ? W'(-dz) : dz[W-1:0];

  assign entry_o = {ign, nx, ny, nz, ne, nf, ax, ay, az, de};

  // The held position follows every accepted move.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q <= '0;
      last_y_q <= '0;
      last_z_q <= '0;
      last_e_q <= '0;
      last_f_q <= '0;
    end else if (push_i && !ign) begin
      last_x_q <= nx;
      last_y_q <= ny;
      last_z_q <= nz;
      last_e_q <= ne;
      last_f_q <= nf;
    end
  end

endmodule

// File: design/gmc_queue.sv
module gmc_queue #(
  parameter int unsigned EW = 290
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [EW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [EW-1:0] pop_data_o
);

  logic [EW-1:0] mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_q];

  // Two-word queue between the front and the back end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

// File: design/gmc_back.sv
module gmc_back #(
  parameter int unsigned W  = 32,
  parameter int unsigned F  = 16,
  parameter int unsigned EW = 8 * W + 34
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [EW-1:0]       entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          move_class_o,
  output logic [W-1:0]        out_x_o,
  output logic [W-1:0]        out_y_o,
  output logic [W-1:0]        out_z_o,
  output logic [W-1:0]        out_e_o,
  output logic [31:0]         out_feed_o,
  output logic [W:0]          move_length_o,
  output logic [W:0]          extrude_delta_o,
  output logic [31:0]         flow_ratio_o
);

  localparam int unsigned SW = 2 * W + 2;
  localparam int unsigned NB = W + F;
  localparam int unsigned RW = W + 4;
  localparam int unsigned QW = (NB > 33) ? NB : 33;
  localparam int unsigned CW = $clog2(NB + 1);

  gmc_pkg::back_state_e st_q;
  logic          ign_q;
  logic [W-1:0]  x_q, y_q, z_q, e_q, ay_q, az_q, mplier_q;
  logic [31:0]   f_q;
  logic [W:0]    de_q, root_q;
  logic [SW-1:0] sum_q, mcand_q;
  logic [RW-1:0] rem_q, r2, trial, dr2;
  logic [NB-1:0] dvd_q, q_q;
  logic [CW-1:0] cnt_q;
  logic [1:0]    axis_q;
  logic [W-1:0]  mag;
  logic [QW-1:0] qe;
  logic          big, neg;

  // Unpack the queue word.
  logic          e_ign;
  logic [W-1:0]  e_x, e_y, e_z, e_e, e_ax, e_ay, e_az;
  logic [31:0]   e_f;
  logic [W:0]    e_de;
  assign {e_ign, e_x, e_y, e_z, e_e, e_f, e_ax, e_ay, e_az, e_de} = entry_i;

  assign pop_o = (st_q == gmc_pkg::ST_IDLE) && valid_i;
  assign mag   = de_q[W] ? W'(-de_q) : de_q[W-1:0];

  // Root step and divide step.
  assign r2    = {rem_q[RW-3:0], sum_q[SW-1:SW-2]};
  assign trial = RW'({root_q, 2'b01});
  assign dr2   = {rem_q[RW-2:0], dvd_q[NB-1]};

  // Sequencer: square sum, square root, then the flow divide; an ignored code skips to the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= gmc_pkg::ST_IDLE;
    end else begin
      case (st_q)
        gmc_pkg::ST_IDLE: begin
          if (valid_i) st_q <= e_ign ? gmc_pkg::ST_DONE : gmc_pkg::ST_SQR;
        end
        gmc_pkg::ST_SQR: begin
          if (cnt_q == CW'(W - 1) && axis_q == 2'd2) st_q <= gmc_pkg::ST_ROOT;
        end
        gmc_pkg::ST_ROOT: begin
          if (cnt_q == CW'(W)) st_q <= gmc_pkg::ST_DIV;
        end
        gmc_pkg::ST_DIV: begin
          if (cnt_q == CW'(NB - 1)) st_q <= gmc_pkg::ST_DONE;
        end
        gmc_pkg::ST_DONE: begin
          if (!out_stall_i) st_q <= gmc_pkg::ST_IDLE;
        end
        default: st_q <= gmc_pkg::ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (st_q)
      gmc_pkg::ST_IDLE: begin
        ign_q    <= e_ign;
        x_q      <= e_x;
        y_q      <= e_y;
        z_q      <= e_z;
        e_q      <= e_e;
        f_q      <= e_f;
        de_q     <= e_de;
        ay_q     <= e_ay;
        az_q     <= e_az;
        mplier_q <= e_ax;
        mcand_q  <= SW'(e_ax);
        sum_q    <= '0;
        axis_q   <= 2'd0;
        cnt_q    <= '0;
      end
      gmc_pkg::ST_SQR: begin
        if (mplier_q[0]) sum_q <= sum_q + mcand_q;
        if (cnt_q == CW'(W - 1)) begin
          cnt_q  <= '0;
          axis_q <= axis_q + 2'd1;
          rem_q  <= '0;
          root_q <= '0;
          if (axis_q == 2'd0) begin
            mplier_q <= ay_q;
            mcand_q  <= SW'(ay_q);
          end else begin
            mplier_q <= az_q;
            mcand_q  <= SW'(az_q);
          end
        end else begin
          cnt_q    <= cnt_q + CW'(1);
          mplier_q <= mplier_q >> 1;
          mcand_q  <= mcand_q << 1;
        end
      end
      gmc_pkg::ST_ROOT: begin
        sum_q <= sum_q << 2;
        if (r2 >= trial) begin
          root_q <= {root_q[W-1:0], 1'b1};
        end else begin
          root_q <= {root_q[W-1:0], 1'b0};
        end
        if (cnt_q == CW'(W)) begin
          cnt_q <= '0;
          rem_q <= '0;
          dvd_q <= NB'(mag) << F;
          q_q   <= '0;
        end else begin
          cnt_q <= cnt_q + CW'(1);
          rem_q <= (r2 >= trial) ? r2 - trial : r2;
        end
      end
      gmc_pkg::ST_DIV: begin
        dvd_q <= dvd_q << 1;
        cnt_q <= cnt_q + CW'(1);
        if (dr2 >= RW'(root_q)) begin
          rem_q <= dr2 - RW'(root_q);
          q_q   <= {q_q[NB-2:0], 1'b1};
        end else begin
          rem_q <= dr2;
          q_q   <= {q_q[NB-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  // Result word; an ignored code reads as all zero.
  assign qe  = QW'(q_q);
  assign big = |qe[QW-1:31];
  assign neg = de_q[W];

  always_comb begin
    move_class_o    = '0;
    out_x_o         = '0;
    out_y_o         = '0;
    out_z_o         = '0;
    out_e_o         = '0;
    out_feed_o      = '0;
    move_length_o   = '0;
    extrude_delta_o = '0;
    flow_ratio_o    = '0;
    if (!ign_q) begin
      out_x_o         = x_q;
      out_y_o         = y_q;
      out_z_o         = z_q;
      out_e_o         = e_q;
      out_feed_o      = f_q;
      move_length_o   = root_q;
      extrude_delta_o = de_q;
      if (root_q != '0) begin
        move_class_o = (de_q != '0) ? gmc_pkg::CLS_EXTRUDE : gmc_pkg::CLS_TRAVEL;
        if (big) flow_ratio_o = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else flow_ratio_o = neg ? (32'd0 - qe[31:0]) : qe[31:0];
      end else begin
        move_class_o = (!neg && de_q != '0) ? gmc_pkg::CLS_PRIME : gmc_pkg::CLS_SUCK;
      end
    end
  end

  assign out_valid_o = st_q == gmc_pkg::ST_DONE;

endmodule
